[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[design/ptcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcc_pkg
// shared types and constants of the parent table cycle check unit
// ----------------------------------------------------------------------------
package ptcc_pkg;

  // table geometry
  localparam int unsigned ENT_W       = 8;
  localparam int unsigned TABLE_DEPTH = 256;

  // request kinds
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_GET  = 2'd1,
    OP_FIND = 2'd2
  } op_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_GET,
    ST_SCAN,
    ST_DONE
  } state_t;

  // one parent link as stored in the table
  typedef struct packed {
    logic             valid;
    logic [ENT_W-1:0] parent;
  } link_t;

  // access bundle from the sequencer to the table
  typedef struct packed {
    logic             rd_en;
    logic [ENT_W-1:0] rd_addr;
    logic             wr_en;
    logic [ENT_W-1:0] wr_addr;
    link_t            wr_link;
  } tbl_req_t;

endpackage

[design/parent_table_cycle_check_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parent_table_cycle_check_unit
// parent link table with set, get and find-next-child requests
// ----------------------------------------------------------------------------
// Handles one request at a time; the table is a memory with a registered read
// that is accessed at most once per cycle. A get reads the child's entry, or
// skips the read when it names no valid child. A set walks up from the new
// parent with one table read per ancestor (at most MAX_ENTITIES reads), or
// does not walk when rejected up front or when it clears a link. A find reads
// one entry per step of its scan (at most 256 entries). An unused op code
// returns a result with ok low. A new request is taken once the previous
// result sits in the output register, even while that result waits to be
// taken. Links are cleared at reset by per-entry valid flops, so no clearing
// pass is needed.
module parent_table_cycle_check_unit #(
  parameter int unsigned MAX_ENTITIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // child[7:0], child_valid[8], parent[16:9],
                                 // parent_valid[17], zero pad[23:18]
  input  logic [1:0]  in_tuser,  // op[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // ok[0], found_entity[8:1], found_valid[9],
                                 // zero pad[15:10]
);

  localparam int unsigned ENT_W   = ptcc_pkg::ENT_W;
  localparam int unsigned LIM     = (MAX_ENTITIES > ptcc_pkg::TABLE_DEPTH) ?
                                    ptcc_pkg::TABLE_DEPTH : MAX_ENTITIES;
  localparam logic [ENT_W:0] LIM_W = (ENT_W+1)'(LIM);
  localparam int unsigned STEP_W  = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_ENTITIES - 1);

  // request fields
  logic [ENT_W-1:0] in_child;
  logic             in_child_valid;
  logic [ENT_W-1:0] in_parent;
  logic             in_parent_valid;
  ptcc_pkg::op_t    in_op;

  assign in_child        = in_tdata[7:0];
  assign in_child_valid  = in_tdata[8];
  assign in_parent       = in_tdata[16:9];
  assign in_parent_valid = in_tdata[17];
  assign in_op           = ptcc_pkg::op_t'(in_tuser);

  ptcc_pkg::state_t   state_r, state_nxt;
  logic [ENT_W-1:0]   kid_r, kid_nxt;
  logic [ENT_W-1:0]   par_r, par_nxt;
  ptcc_pkg::link_t    want_r, want_nxt;
  logic [ENT_W:0]     idx_r, idx_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [ENT_W-1:0]   res_ent_r, res_ent_nxt;
  logic               res_fv_r, res_fv_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [ENT_W-1:0]   out_ent_r, out_ent_nxt;
  logic               out_fv_r, out_fv_nxt;

  ptcc_pkg::tbl_req_t tbl_req;
  ptcc_pkg::link_t    rd_link;
  logic [ENT_W:0]     find_start;
  logic [ENT_W:0]     idx_inc;

  ptcc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_link (rd_link)
  );

  assign find_start = in_child_valid ? ({1'b0, in_child} + (ENT_W+1)'(1)) : '0;
  assign idx_inc    = idx_r + (ENT_W+1)'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptcc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    kid_r     <= kid_nxt;
    par_r     <= par_nxt;
    want_r    <= want_nxt;
    idx_r     <= idx_nxt;
    steps_r   <= steps_nxt;
    res_ok_r  <= res_ok_nxt;
    res_ent_r <= res_ent_nxt;
    res_fv_r  <= res_fv_nxt;
    out_ok_r  <= out_ok_nxt;
    out_ent_r <= out_ent_nxt;
    out_fv_r  <= out_fv_nxt;
  end

  // sequencer: decode, walk, scan and result hand-off
  always_comb begin
    state_nxt     = state_r;
    kid_nxt       = kid_r;
    par_nxt       = par_r;
    want_nxt      = want_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    res_ok_nxt    = res_ok_r;
    res_ent_nxt   = res_ent_r;
    res_fv_nxt    = res_fv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_ent_nxt   = out_ent_r;
    out_fv_nxt    = out_fv_r;
    tbl_req       = '0;
    in_tready     = 1'b0;

    unique case (state_r)
      ptcc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kid_nxt     = in_child;
          par_nxt     = in_parent;
          steps_nxt   = '0;
          res_ok_nxt  = 1'b0;
          res_ent_nxt = '0;
          res_fv_nxt  = 1'b0;
          state_nxt   = ptcc_pkg::ST_DONE;
          unique case (in_op)
            ptcc_pkg::OP_SET: begin
              priority if (!in_child_valid || ({1'b0, in_child} >= LIM_W)) begin
                res_ok_nxt = 1'b0;
              end else if (!in_parent_valid) begin
                // clear the link
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = in_child;
                tbl_req.wr_link = '0;
                res_ok_nxt      = 1'b1;
              end else if (({1'b0, in_parent} >= LIM_W) || (in_parent == in_child)) begin
                res_ok_nxt = 1'b0;
              end else begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = in_parent;
                state_nxt       = ptcc_pkg::ST_WALK;
              end
            end
            ptcc_pkg::OP_GET: begin
              if (in_child_valid && ({1'b0, in_child} < LIM_W)) begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = in_child;
                state_nxt       = ptcc_pkg::ST_GET;
              end
            end
            ptcc_pkg::OP_FIND: begin
              want_nxt.valid  = in_parent_valid;
              want_nxt.parent = in_parent_valid ? in_parent : '0;
              idx_nxt         = find_start;
              if (find_start < LIM_W) begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = find_start[ENT_W-1:0];
                state_nxt       = ptcc_pkg::ST_SCAN;
              end
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end
      end

      ptcc_pkg::ST_WALK: begin
        // one ancestor per cycle
        priority if (!rd_link.valid) begin
          tbl_req.wr_en          = 1'b1;
          tbl_req.wr_addr        = kid_r;
          tbl_req.wr_link.valid  = 1'b1;
          tbl_req.wr_link.parent = par_r;
          res_ok_nxt             = 1'b1;
          state_nxt              = ptcc_pkg::ST_DONE;
        end else if (rd_link.parent == kid_r) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ptcc_pkg::ST_DONE;
        end else if (steps_r == STEP_LAST) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ptcc_pkg::ST_DONE;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = rd_link.parent;
          steps_nxt       = steps_r + STEP_W'(1);
        end
      end

      ptcc_pkg::ST_GET: begin
        res_ok_nxt  = rd_link.valid;
        res_fv_nxt  = rd_link.valid;
        res_ent_nxt = rd_link.parent;
        state_nxt   = ptcc_pkg::ST_DONE;
      end

      ptcc_pkg::ST_SCAN: begin
        // one entry per cycle
        priority if (rd_link == want_r) begin
          res_ok_nxt  = 1'b1;
          res_fv_nxt  = 1'b1;
          res_ent_nxt = idx_r[ENT_W-1:0];
          state_nxt   = ptcc_pkg::ST_DONE;
        end else if (idx_inc >= LIM_W) begin
          state_nxt = ptcc_pkg::ST_DONE;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = idx_inc[ENT_W-1:0];
          idx_nxt         = idx_inc;
        end
      end

      ptcc_pkg::ST_DONE: begin
        // move the result into the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_ent_nxt   = res_ent_r;
          out_fv_nxt    = res_fv_r;
          state_nxt     = ptcc_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_fv_r, out_ent_r, out_ok_r};

  // checks
`include "assert_macros.svh"

  `ASSERT_NEVER(a_no_rd_wr_same_cycle, clk, rst_n, tbl_req.rd_en && tbl_req.wr_en)
  `ASSERT_NEVER(a_no_self_link, clk, rst_n,
                tbl_req.wr_en && tbl_req.wr_link.valid &&
                (tbl_req.wr_link.parent == tbl_req.wr_addr))
  `ASSERT_PROP(a_busy_after_request, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  `ASSERT_PROP(a_found_implies_ok, clk, rst_n, (out_valid_r && out_fv_r) |-> out_ok_r)

endmodule

[design/ptcc_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcc_table
// parent link memory with one read and one write port, per-entry valid flops
// ----------------------------------------------------------------------------
module ptcc_table (
  input  logic             clk,
  input  logic             rst_n,
  input  ptcc_pkg::tbl_req_t req,
  output ptcc_pkg::link_t  rd_link
);

  logic [ptcc_pkg::ENT_W-1:0] mem [ptcc_pkg::TABLE_DEPTH];
  logic [ptcc_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [ptcc_pkg::ENT_W-1:0] rd_par_r;
  logic                       rd_valid_r;

  // valid bits, cleared at reset so every entry reads as no parent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= req.wr_link.valid;
    end
  end

  // parent field storage
  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_link.valid) begin
      mem[req.wr_addr] <= req.wr_link.parent;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_par_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  // an entry without a link reads as all zeros
  assign rd_link.valid  = rd_valid_r;
  assign rd_link.parent = rd_valid_r ? rd_par_r : '0;

endmodule
